### sv/wbfv_pkg.sv
// Package for the log frame validator: field widths, limits, status codes
// and the byte-wide CRC-32 step. No dependencies.
`default_nettype none
package wbfv_pkg;
  localparam int unsigned MAX_FRAME_BYTES = 134217728;
  localparam int unsigned MAX_KEY_BYTES   = 1048576;
  localparam int unsigned MAX_VALUE_BYTES = 16777216;
  localparam int unsigned MAX_OPS         = 1000000;
  localparam int unsigned MIN_FRAME       = 4 + 4 + 4 + 8 + 4 + 4;
  localparam logic [47:0] OFFSET_MAX      = 48'hFFFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    REG_INIT_SEQ = 2'd0,
    REG_PUT_CODE = 2'd1,
    REG_DEL_CODE = 2'd2
  } reg_index_t;

  typedef enum logic [3:0] {
    ST_COMMIT    = 4'd0,
    ST_CLEAN_END = 4'd1,
    ST_TORN      = 4'd2,
    ST_LENGTH    = 4'd3,
    ST_MAGIC     = 4'd4,
    ST_VERSION   = 4'd5,
    ST_CRC       = 4'd6,
    ST_SEQ_GAP   = 4'd7,
    ST_COUNT     = 4'd8,
    ST_OP_HDR    = 4'd9,
    ST_OP_BOUNDS = 4'd10,
    ST_OP_TRUNC  = 4'd11,
    ST_OP_TYPE   = 4'd12,
    ST_DEL_VALUE = 4'd13,
    ST_TRAILING  = 4'd14
  } status_t;

  typedef struct packed {
    logic [47:0] last_good_offset;
    logic [31:0] committed_total;
    logic [19:0] frame_op_count;
    logic [63:0] frame_sequence;
    status_t     status;
  } result_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] x;
    x = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      x = x[0] ? ((x >> 1) ^ 32'hEDB88320) : (x >> 1);
    end
    return x;
  endfunction
endpackage
`default_nettype wire

### sv/wal_batch_frame_validator.sv
// Top level of the log frame validator: stream ports, configuration,
// frame header checks, CRC and result register. Depends on wbfv_pkg, wbfv_op_parser.
`default_nettype none
// Takes one log transfer per cycle, back to back, and gives a registered result
// in the cycle after the byte that ends a frame, fails a check or marks end of
// log. Each byte ahead of the trailer CRC passes one CRC-32 byte step and the
// field checks between the input and the result register. A result waiting in
// the output register stalls input until it is taken. After an error or end of
// log the block ignores all input until reset.
module wal_batch_frame_validator (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [7:0]   s_tdata,   // data_byte
  input  wire logic         s_tlast,   // end_of_log
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [167:0]      m_tdata,   // status, frame_sequence, frame_op_count,
                                       // committed_total, last_good_offset
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [63:0]  cfg_data
);
  import wbfv_pkg::*;

  logic [7:0]  put_code, del_code;
  logic [27:0] idx;
  logic [31:0] frame_length, running_crc, trailer_crc, op_count;
  logic [63:0] seq_accum, prior_seq;
  logic [1:0]  hdr_faults;
  logic [31:0] committed;
  logic [47:0] offset;
  logic        halted;
  result_t     res;

  status_t     op_fault;
  logic        op_fault_valid, ops_short;
  logic        accept, in_ops, clear, frame_end;
  logic [31:0] len_next;
  status_t     fin_status;
  logic [48:0] off_sum;
  logic [47:0] off_sat;
  logic [31:0] committed_inc;
  result_t     res_next;
  logic        res_load, halt_set, commit;

  assign s_tready  = !m_tvalid || m_tready;
  assign cfg_ready = 1'b1;
  assign accept    = s_tvalid && s_tready && !halted;
  assign len_next  = {frame_length[23:0], s_tdata};
  assign in_ops    = accept && !s_tlast && idx >= 28'd24
                     && {4'd0, idx} < frame_length - 32'd4;
  assign frame_end = accept && !s_tlast && idx >= 28'd4
                     && {4'd0, idx} == frame_length - 32'd1;
  assign clear     = rst || frame_end;
  assign off_sum   = {1'b0, offset} + {17'd0, frame_length};
  assign off_sat   = (off_sum > {1'b0, OFFSET_MAX}) ? OFFSET_MAX : off_sum[47:0];
  assign committed_inc = (committed != 32'hFFFF_FFFF) ? committed + 32'd1 : committed;
  assign m_tdata   = res;

  always_comb begin
    if (hdr_faults[0]) fin_status = ST_MAGIC;
    else if (hdr_faults[1]) fin_status = ST_VERSION;
    else if ({trailer_crc[23:0], s_tdata} != ~running_crc) fin_status = ST_CRC;
    else if (seq_accum != prior_seq + 64'd1) fin_status = ST_SEQ_GAP;
    else if (op_count == 0 || op_count > MAX_OPS) fin_status = ST_COUNT;
    else if (op_fault_valid) fin_status = op_fault;
    else if (ops_short) fin_status = ST_OP_HDR;
    else fin_status = ST_COMMIT;
  end

  always_comb begin
    res_next.status           = ST_COMMIT;
    res_next.frame_sequence   = prior_seq;
    res_next.frame_op_count   = '0;
    res_next.committed_total  = committed;
    res_next.last_good_offset = offset;
    res_load = 1'b0;
    halt_set = 1'b0;
    commit   = 1'b0;
    if (accept) begin
      if (s_tlast) begin
        res_load = 1'b1;
        halt_set = 1'b1;
        res_next.status = (idx == 28'd0) ? ST_CLEAN_END : ST_TORN;
      end else if (idx == 28'd3 && (len_next < MIN_FRAME || len_next > MAX_FRAME_BYTES)) begin
        res_load = 1'b1;
        halt_set = 1'b1;
        res_next.status = ST_LENGTH;
      end else if (frame_end) begin
        res_load = 1'b1;
        res_next.status = fin_status;
        if (fin_status != ST_COMMIT) begin
          halt_set = 1'b1;
        end else begin
          commit = 1'b1;
          res_next.frame_sequence   = seq_accum;
          res_next.frame_op_count   = op_count[19:0];
          res_next.committed_total  = committed_inc;
          res_next.last_good_offset = off_sat;
        end
      end
    end
  end

  wbfv_op_parser u_ops (
    .clk, .clear, .step(in_ops), .data_byte(s_tdata), .idx, .frame_length,
    .op_count, .put_code, .del_code, .fault(op_fault), .fault_valid(op_fault_valid),
    .ops_short
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      put_code <= 8'd0; del_code <= 8'd1;
      prior_seq <= '0; committed <= '0; offset <= '0; halted <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (res_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      if (res_load) res <= res_next;
      if (halt_set) halted <= 1'b1;
      if (commit) begin
        prior_seq <= seq_accum;
        committed <= committed_inc;
        offset <= off_sat;
      end else if (cfg_valid && cfg_index == REG_INIT_SEQ && committed == 32'd0) begin
        prior_seq <= cfg_data;
      end
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_PUT_CODE: put_code <= cfg_data[7:0];
          REG_DEL_CODE: del_code <= cfg_data[7:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clear) begin
      idx <= '0; frame_length <= '0; running_crc <= '1; trailer_crc <= '0;
      hdr_faults <= '0; seq_accum <= '0; op_count <= '0;
    end else if (accept && !s_tlast) begin
      idx <= idx + 28'd1;
      if (idx < 28'd4) begin
        running_crc <= crc_byte(running_crc, s_tdata);
        frame_length <= len_next;
      end else if ({4'd0, idx} < frame_length - 32'd4) begin
        running_crc <= crc_byte(running_crc, s_tdata);
        if (idx < 28'd8) begin
          if (s_tdata != (idx == 28'd4 ? 8'h42 : idx == 28'd5 ? 8'h44 :
                          idx == 28'd6 ? 8'h57 : 8'h34)) hdr_faults[0] <= 1'b1;
        end else if (idx < 28'd12) begin
          if (s_tdata != ((idx == 28'd11) ? 8'd4 : 8'd0)) hdr_faults[1] <= 1'b1;
        end else if (idx < 28'd20) begin
          seq_accum <= {seq_accum[55:0], s_tdata};
        end else if (idx < 28'd24) begin
          op_count <= {op_count[23:0], s_tdata};
        end
      end else begin
        trailer_crc <= {trailer_crc[23:0], s_tdata};
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    halted |=> halted) else $error("halt flag dropped");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(res)) else $error("result lost");
  a_commit_count: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) && committed != $past(committed) |-> committed == $past(committed) + 32'd1)
    else $error("commit count jump");
  a_no_accept_halted: assert property (@(posedge clk) disable iff (rst)
    halted |-> !accept) else $error("accepted while halted");
`endif
endmodule
`default_nettype wire

### sv/wbfv_op_parser.sv
// Operation record walker for one frame: tracks the op header, payload
// bytes and the first fault seen. Depends on wbfv_pkg.
`default_nettype none
module wbfv_op_parser (
  input  wire logic        clk,
  input  wire logic        clear,
  input  wire logic        step,
  input  wire logic [7:0]  data_byte,
  input  wire logic [27:0] idx,
  input  wire logic [31:0] frame_length,
  input  wire logic [31:0] op_count,
  input  wire logic [7:0]  put_code,
  input  wire logic [7:0]  del_code,
  output wbfv_pkg::status_t fault,
  output logic             fault_valid,
  output logic             ops_short
);
  import wbfv_pkg::*;

  logic        phase;
  logic [3:0]  hdr_index;
  logic [7:0]  type_byte;
  logic [31:0] key_length;
  logic [31:0] value_length;
  logic [31:0] payload_left;
  logic [20:0] ops_seen;

  logic [31:0] room_now;
  logic [32:0] need;
  logic [31:0] vlen_new;
  assign room_now = frame_length - 32'd4 - {4'd0, idx};
  assign vlen_new = {value_length[23:0], data_byte};
  assign need     = {1'b0, key_length} + {1'b0, vlen_new};
  assign ops_short = {11'd0, ops_seen} < op_count;

  always_ff @(posedge clk) begin
    if (clear) begin
      phase <= 1'b0;
      hdr_index <= '0;
      key_length <= '0;
      value_length <= '0;
      payload_left <= '0;
      ops_seen <= '0;
      fault_valid <= 1'b0;
      fault <= ST_COMMIT;
    end else if (step && !fault_valid) begin
      if (!phase) begin
        hdr_index <= (hdr_index == 4'd8) ? 4'd0 : hdr_index + 4'd1;
        if (hdr_index == 4'd0) begin
          if ({11'd0, ops_seen} >= op_count) begin
            fault_valid <= 1'b1;
            fault <= ST_TRAILING;
          end else if (room_now < 32'd9) begin
            fault_valid <= 1'b1;
            fault <= ST_OP_HDR;
          end
          type_byte <= data_byte;
        end else if (hdr_index <= 4'd4) begin
          key_length <= {key_length[23:0], data_byte};
        end else if (hdr_index != 4'd8) begin
          value_length <= vlen_new;
        end else begin
          value_length <= vlen_new;
          if (key_length == 0 || key_length > MAX_KEY_BYTES
              || vlen_new > MAX_VALUE_BYTES) begin
            fault_valid <= 1'b1;
            fault <= ST_OP_BOUNDS;
          end else if (need > {1'b0, room_now - 32'd1}) begin
            fault_valid <= 1'b1;
            fault <= ST_OP_TRUNC;
          end else if (type_byte != put_code && type_byte != del_code) begin
            fault_valid <= 1'b1;
            fault <= ST_OP_TYPE;
          end else if (type_byte != put_code && vlen_new != 0) begin
            fault_valid <= 1'b1;
            fault <= ST_DEL_VALUE;
          end else begin
            payload_left <= need[31:0];
            phase <= 1'b1;
          end
        end
      end else begin
        payload_left <= payload_left - 32'd1;
        if (payload_left == 32'd1) begin
          ops_seen <= ops_seen + 21'd1;
          phase <= 1'b0;
        end
      end
    end
  end
endmodule
`default_nettype wire
